/* rtl/core/prf_pkg.sv */
package prf_pkg;

	localparam int WIDTH = 16;
	localparam int EXP_W = 4;
	localparam logic [EXP_W-1:0] EXP_MAX = '1;

	typedef struct packed {
		logic             start;
		logic [WIDTH-1:0] dividend;
		logic [WIDTH-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [WIDTH-1:0] quotient;
		logic [WIDTH-1:0] remainder;
	} div_rsp_t;

	typedef struct packed {
		logic [WIDTH-1:0] factor;
		logic [EXP_W-1:0] exponent;
		logic             trivial;
		logic             last;
	} pair_t;

endpackage

/* rtl/core/prf_div.sv */
module prf_div
	import prf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(WIDTH);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH+1:0] diff;

	// restoring step: one quotient bit a cycle
	assign diff = {1'b0, rem_q, quo_q[WIDTH-1]} - {2'b00, req.divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				quo_q  <= req.dividend;
			end else if (busy_q) begin
				if (diff[WIDTH+1]) begin
					rem_q <= {rem_q[WIDTH-2:0], quo_q[WIDTH-1]};
				end else begin
					rem_q <= diff[WIDTH-1:0];
				end
				quo_q <= {quo_q[WIDTH-2:0], ~diff[WIDTH+1]};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

/* rtl/core/prime_factorizer.sv */
// channel | dir | tdata (lsb up)              | side bands
// s       | in  | number[15:0]                | -
// m       | out | factor[15:0], exponent[19:16], pad | tuser = no_factor_found, tlast
//
// Each trial divisor of a number takes a square compare, a divider start and a restoring
// division in the single divider, which runs once more for every time the divisor
// divides. Worst case is a prime near 65535.
// arst_n clears the sequencer and both beat registers.
// s_tready is high only while idle; a held m beat stalls the sequencer only when
// it next has a pair to write.
module prime_factorizer
	import prf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // number
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // factor, exponent, zero pad
	output logic        m_tuser,  // no_factor_found
	output logic        m_tlast
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CMP   = 4'd1;
	localparam logic [3:0] S_DST   = 4'd2;
	localparam logic [3:0] S_DIV   = 4'd3;
	localparam logic [3:0] S_PAIR  = 4'd4;
	localparam logic [3:0] S_FIN   = 4'd5;
	localparam logic [3:0] S_FLUSH = 4'd6;
	localparam logic [3:0] S_TRIV1 = 4'd7;
	localparam logic [3:0] S_TRIV2 = 4'd8;

	logic [3:0]       state_q;
	logic [WIDTH-1:0] n_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] d_q;
	logic [EXP_W-1:0] exp_q;
	logic             pend_v_q;
	pair_t            pend_q;
	logic             out_v_q;
	pair_t            out_q;
	logic [2*WIDTH-1:0] sq;
	logic             tail;
	div_req_t         div_req;
	div_rsp_t         div_rsp;

	assign sq   = (2*WIDTH)'(d_q) * (2*WIDTH)'(d_q);
	assign tail = (rem_q > WIDTH'(1)) && (rem_q != n_q);

	assign div_req.start    = (state_q == S_DST);
	assign div_req.dividend = rem_q;
	assign div_req.divisor  = d_q;

	prf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			n_q      <= '0;
			rem_q    <= '0;
			d_q      <= '0;
			exp_q    <= '0;
			pend_v_q <= 1'b0;
			pend_q   <= '0;
			out_v_q  <= 1'b0;
			out_q    <= '0;
		end else begin
			if (m_tready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						n_q      <= s_tdata;
						rem_q    <= s_tdata;
						d_q      <= WIDTH'(2);
						exp_q    <= '0;
						pend_v_q <= 1'b0;
						state_q  <= S_CMP;
					end
				end
				S_CMP: begin
					if (sq > (2*WIDTH)'(rem_q)) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_DST;
					end
				end
				S_DST: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						if (div_rsp.remainder == '0) begin
							rem_q   <= div_rsp.quotient;
							exp_q   <= (exp_q == EXP_MAX) ? exp_q : exp_q + 1'b1;
							state_q <= S_DST;
						end else if (exp_q != '0) begin
							state_q <= S_PAIR;
						end else begin
							d_q     <= d_q + 1'b1;
							state_q <= S_CMP;
						end
					end
				end
				S_PAIR: begin
					if (!pend_v_q || !out_v_q) begin
						if (pend_v_q) begin
							out_q   <= pend_q;
							out_v_q <= 1'b1;
						end
						pend_v_q <= 1'b1;
						pend_q   <= '{factor: d_q, exponent: exp_q, trivial: 1'b0, last: 1'b0};
						exp_q    <= '0;
						d_q      <= d_q + 1'b1;
						state_q  <= S_CMP;
					end
				end
				S_FIN: begin
					if (!tail) begin
						state_q <= S_FLUSH;
					end else if (!pend_v_q || !out_v_q) begin
						if (pend_v_q) begin
							out_q   <= pend_q;
							out_v_q <= 1'b1;
						end
						pend_v_q <= 1'b1;
						pend_q   <= '{factor: rem_q, exponent: EXP_W'(1), trivial: 1'b0,
							last: 1'b0};
						state_q  <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= S_TRIV1;
					end else if (!out_v_q) begin
						out_q    <= '{factor: pend_q.factor, exponent: pend_q.exponent,
							trivial: pend_q.trivial, last: 1'b1};
						out_v_q  <= 1'b1;
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				S_TRIV1: begin
					if (!out_v_q) begin
						out_v_q <= 1'b1;
						if (n_q == '0) begin
							out_q   <= '{factor: '0, exponent: EXP_W'(1), trivial: 1'b1,
								last: 1'b0};
							state_q <= S_TRIV2;
						end else if (n_q == WIDTH'(1)) begin
							out_q   <= '{factor: WIDTH'(1), exponent: EXP_W'(1), trivial: 1'b1,
								last: 1'b1};
							state_q <= S_IDLE;
						end else begin
							out_q   <= '{factor: WIDTH'(1), exponent: EXP_W'(1), trivial: 1'b1,
								last: 1'b0};
							state_q <= S_TRIV2;
						end
					end
				end
				S_TRIV2: begin
					if (!out_v_q) begin
						out_v_q <= 1'b1;
						if (n_q == '0) begin
							out_q <= '{factor: WIDTH'(1), exponent: EXP_W'(1), trivial: 1'b1,
								last: 1'b1};
						end else begin
							out_q <= '{factor: n_q, exponent: EXP_W'(1), trivial: 1'b1,
								last: 1'b1};
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_v_q;
	assign m_tdata  = {4'd0, out_q.exponent, out_q.factor};
	assign m_tuser  = out_q.trivial;
	assign m_tlast  = out_q.last;

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DIV)
		else $error("divider finished outside division wait");

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !pend_v_q)
		else $error("pair left pending while idle");

	a_exp_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[19:16] != 4'd0)
		else $error("zero exponent on output beat");

	a_start_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> state_q == S_CMP && d_q == WIDTH'(2))
		else $error("accepted number did not start at divisor two");

endmodule
